### hdl/mft_pkg.sv
// Shared widths, register codes and record types of the multi-turn tracker.
package mft_pkg;

  localparam int ID_W    = 11;
  localparam int ANGLE_W = 13;
  localparam int TURN_W  = 16;
  localparam int DATA_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int IDX_W   = 4;
  localparam int TOTAL_W = 30;

  // APB register map: one 32-bit register, index in paddr[ADDR_W-1:2]
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_BASE_FRAME_ID = '0;
  localparam logic [ID_W-1:0] BASE_FRAME_ID_RESET = 11'd513;

  // Half a revolution in encoder counts
  localparam logic signed [ANGLE_W:0] HALF_TURN     = 14'sd4096;
  localparam logic signed [ANGLE_W:0] NEG_HALF_TURN = -14'sd4096;

  // One motor record as stored in the record memory
  typedef struct packed {
    logic [ANGLE_W-1:0] prev_angle;
    logic [TURN_W-1:0]  turns;
    logic [ANGLE_W-1:0] origin_angle;
    logic [DATA_W-1:0]  prev_speed;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Angle results handed from the update logic to the output stage
  typedef struct packed {
    logic [TOTAL_W-1:0] total_angle;
    logic [TURN_W-1:0]  turn_count;
  } upd_t;

endpackage

### hdl/mft_intf.sv
// Valid/ready channel interfaces for feedback frames and tracker results.
interface mft_feedback_if;
  logic                                valid;
  logic                                ready;
  logic                                bus;
  logic [mft_pkg::ID_W-1:0]            frame_id;
  logic [mft_pkg::ANGLE_W-1:0]         rx_angle;
  logic signed [mft_pkg::DATA_W-1:0]   rx_speed;
  logic signed [mft_pkg::DATA_W-1:0]   rx_current;
  logic [mft_pkg::TEMP_W-1:0]          rx_temp;

  modport source (output valid, bus, frame_id, rx_angle, rx_speed, rx_current, rx_temp,
                  input ready);
  modport sink (input valid, bus, frame_id, rx_angle, rx_speed, rx_current, rx_temp,
                output ready);
endinterface

interface mft_result_if;
  logic                                valid;
  logic                                ready;
  logic                                matched;
  logic [mft_pkg::IDX_W-1:0]           motor_index;
  logic signed [mft_pkg::TOTAL_W-1:0]  total_angle;
  logic signed [mft_pkg::TURN_W-1:0]   turn_count;
  logic signed [mft_pkg::DATA_W-1:0]   speed_now;
  logic signed [mft_pkg::DATA_W-1:0]   speed_before;
  logic signed [mft_pkg::DATA_W-1:0]   current_now;
  logic [mft_pkg::TEMP_W-1:0]          temperature;
  logic                                was_first;

  modport source (output valid, matched, motor_index, total_angle, turn_count, speed_now,
                  speed_before, current_now, temperature, was_first,
                  input ready);
  modport sink (input valid, matched, motor_index, total_angle, turn_count, speed_now,
                speed_before, current_now, temperature, was_first,
                output ready);
endinterface

### hdl/mft_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module mft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mft_cfg.sv
// APB register block holding the base frame identifier.
module mft_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mft_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mft_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mft_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [mft_pkg::ID_W-1:0]        base_frame_id
);

  logic sel_base;

  assign sel_base = (paddr[mft_pkg::APB_ADDR_W-1:2] == mft_pkg::REG_BASE_FRAME_ID);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame_id <= mft_pkg::BASE_FRAME_ID_RESET;
    end else if (psel && penable && pwrite && pready && sel_base) begin
      base_frame_id <= pwdata[mft_pkg::ID_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_base) begin
      prdata = {{(mft_pkg::APB_DATA_W - mft_pkg::ID_W){1'b0}}, base_frame_id};
    end
  end

endmodule

### hdl/mft_update.sv
// Turn counting and multi-turn angle for one motor record.
module mft_update (
  input  logic                          first,
  input  mft_pkg::rec_t                 rec,
  input  logic [mft_pkg::ANGLE_W-1:0]   angle,
  input  logic [mft_pkg::DATA_W-1:0]    speed,
  output mft_pkg::rec_t                 rec_next,
  output mft_pkg::upd_t                 upd
);

  logic signed [mft_pkg::ANGLE_W:0]   delta;
  logic                               step_up;
  logic                               step_down;
  logic [mft_pkg::TURN_W-1:0]         turns_next;
  logic [mft_pkg::TOTAL_W-1:0]        total;

  // Wrap detection: a jump of half a revolution or more crosses zero
  assign delta     = $signed({1'b0, angle}) - $signed({1'b0, rec.prev_angle});
  assign step_up   = (delta <= mft_pkg::NEG_HALF_TURN);
  assign step_down = (delta >= mft_pkg::HALF_TURN);

  always_comb begin
    priority if (first) begin
      turns_next = '0;
    end else if (step_up) begin
      turns_next = rec.turns + 1'b1;
    end else if (step_down) begin
      turns_next = rec.turns - 1'b1;
    end else begin
      turns_next = rec.turns;
    end
  end

  // turns * 8192 sign-extended, plus raw angle minus origin, modulo 2^30
  assign total = {turns_next[mft_pkg::TURN_W-1], turns_next, {mft_pkg::ANGLE_W{1'b0}}}
               + {{(mft_pkg::TOTAL_W - mft_pkg::ANGLE_W){1'b0}}, angle}
               - {{(mft_pkg::TOTAL_W - mft_pkg::ANGLE_W){1'b0}}, rec.origin_angle};

  always_comb begin
    rec_next.prev_angle   = angle;
    rec_next.turns        = turns_next;
    rec_next.origin_angle = first ? angle : rec.origin_angle;
    rec_next.prev_speed   = speed;
    upd.turn_count        = turns_next;
    upd.total_angle       = first ? '0 : total;
  end

endmodule

### hdl/motor_feedback_multiturn_tracker_unit.sv
// Top level of the multi-turn motor feedback tracker.
// Tracks multi-turn position for up to BUS_COUNT * MOTORS_PER_BUS motors from
// their feedback frames. A frame whose identifier lies in the window of
// MOTORS_PER_BUS identifiers starting at base_frame_id (APB register 0, reset
// 513; the window is cut short at identifier 2047) picks record
// bus * MOTORS_PER_BUS + offset; any other frame, or one on a bus at or beyond
// BUS_COUNT, yields a word with every field zero and leaves all records alone.
// A motor's first frame after reset latches its raw angle as origin and reports
// angle 0 with was_first set; later frames count a turn whenever the raw angle
// jumps by half a revolution or more, and report turns * 8192 + angle - origin.
// The turn count wraps at 16 bits. Throughput is one word per clock unless the result
// side stalls; a frame passes the stage 1 register, then the result register. The
// records live in one RAM with a registered read, read as the frame is taken and
// written back as it leaves stage 1; a bypass register of the last write covers a
// frame for the same motor that follows directly. Per-record valid flops, cleared
// by reset, stand in for the first-frame flags, so no clearing pass runs after reset.
module motor_feedback_multiturn_tracker_unit #(
  parameter int MOTORS_PER_BUS = 8,
  parameter int BUS_COUNT      = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  mft_feedback_if.sink                    feedback,
  mft_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mft_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mft_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mft_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int RECORDS = MOTORS_PER_BUS * BUS_COUNT;
  localparam int AW      = (RECORDS > 1) ? $clog2(RECORDS) : 1;

  // ---------------------------------------------------------------- config
  logic [mft_pkg::ID_W-1:0] base_frame_id;

  mft_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .base_frame_id (base_frame_id)
  );

  // ---------------------------------------------------------------- decode
  logic [mft_pkg::ID_W:0]     id_diff;
  logic                       in_match;
  logic [mft_pkg::IDX_W-1:0]  in_idx;
  logic                       in_accept;

  // Window test: id at or above base, less than MOTORS_PER_BUS past it, bus < BUS_COUNT
  assign id_diff  = {1'b0, feedback.frame_id} - {1'b0, base_frame_id};
  assign in_match = !id_diff[mft_pkg::ID_W]
                 && (id_diff[mft_pkg::ID_W-1:0] < mft_pkg::ID_W'(MOTORS_PER_BUS))
                 && ({1'b0, feedback.bus} < 2'(BUS_COUNT));
  assign in_idx   = (feedback.bus ? mft_pkg::IDX_W'(MOTORS_PER_BUS) : '0)
                  + {1'b0, id_diff[2:0]};

  // ---------------------------------------------------------------- stage 1
  logic                        s1_valid;
  logic                        s1_match;
  logic [mft_pkg::IDX_W-1:0]   s1_idx;
  logic [mft_pkg::ANGLE_W-1:0] s1_angle;
  logic [mft_pkg::DATA_W-1:0]  s1_speed;
  logic [mft_pkg::DATA_W-1:0]  s1_current;
  logic [mft_pkg::TEMP_W-1:0]  s1_temp;
  logic [AW-1:0]               s1_addr;
  logic                        out_free;
  logic                        s1_advance;

  assign out_free       = !result.valid || result.ready;
  assign s1_advance     = s1_valid && out_free;
  assign feedback.ready = !s1_valid || out_free;
  assign in_accept      = feedback.valid && feedback.ready;
  assign s1_addr        = s1_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feedback.ready) begin
      s1_valid <= feedback.valid;
    end
  end

  // Payload of stage 1; unmatched words carry zero index
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_match   <= in_match;
      s1_idx     <= in_match ? in_idx : '0;
      s1_angle   <= feedback.rx_angle;
      s1_speed   <= feedback.rx_speed;
      s1_current <= feedback.rx_current;
      s1_temp    <= feedback.rx_temp;
    end
  end

  // ---------------------------------------------------------------- records
  logic                  ram_we;
  logic [mft_pkg::REC_W-1:0] ram_rdata;
  mft_pkg::rec_t         rec_cur;
  mft_pkg::rec_t         rec_next;
  mft_pkg::upd_t         upd;
  logic [RECORDS-1:0]    rec_valid;
  logic                  byp_valid;
  logic [AW-1:0]         byp_addr;
  mft_pkg::rec_t         byp_rec;
  logic                  first;

  assign ram_we = s1_advance && s1_match;

  mft_ram #(
    .WIDTH (mft_pkg::REC_W),
    .DEPTH (RECORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (rec_next),
    .re    (in_accept),
    .raddr (in_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Take the last write when it hit the same record: the RAM read beside it was stale
  assign rec_cur = (byp_valid && (byp_addr == s1_addr)) ? byp_rec : mft_pkg::rec_t'(ram_rdata);
  assign first   = !rec_valid[s1_addr];

  mft_update u_update (
    .first    (first),
    .rec      (rec_cur),
    .angle    (s1_angle),
    .speed    (s1_speed),
    .rec_next (rec_next),
    .upd      (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
      byp_valid <= 1'b0;
    end else if (ram_we) begin
      rec_valid[s1_addr] <= 1'b1;
      byp_valid          <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_addr <= s1_addr;
      byp_rec  <= rec_next;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s1_valid;
    end
  end

  // Load the result word as stage 1 moves on; unmatched frames give all zeros
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.matched      <= s1_match;
      result.motor_index  <= s1_idx;
      result.total_angle  <= s1_match ? upd.total_angle : '0;
      result.turn_count   <= s1_match ? upd.turn_count : '0;
      result.speed_now    <= s1_match ? s1_speed : '0;
      result.speed_before <= (s1_match && !first) ? rec_cur.prev_speed : '0;
      result.current_now  <= s1_match ? s1_current : '0;
      result.temperature  <= s1_match ? s1_temp : '0;
      result.was_first    <= s1_match && first;
    end
  end

`ifndef SYNTHESIS
  // A record written back must read as seen on the next cycle
  a_rec_valid_set: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> rec_valid[$past(s1_addr)])
    else $error("record valid flag not set after write-back");

  // A first frame reports zero angle and zero turns
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.was_first) |-> (result.total_angle == '0 && result.turn_count == '0))
    else $error("first frame reported nonzero angle or turns");

  // Unmatched words are all zero
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.matched) |-> (result.motor_index == '0 && !result.was_first
      && result.speed_now == '0 && result.temperature == '0))
    else $error("unmatched word carries data");

  // A full pipeline with a stalled output takes no new frame
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result.valid && !result.ready) |-> !feedback.ready)
    else $error("frame accepted while pipeline was full");
`endif

endmodule
